FILE: design/dvt_pkg.sv
// Package for the distinct value table: shared widths, sequencer state type
// and the result record passed from the sequencer to the output stage.
// No dependencies.
package dvt_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int ELEM_WIDTH_DEF  = 32;
  localparam int VALUE_W         = 32;
  localparam int MI_W            = 8;
  localparam int OUT_USER_W      = 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } dvt_state_t;

  typedef struct packed {
    logic [MI_W-1:0] match_index;
    logic            is_new;
    logic            overflow;
  } dvt_result_t;

endpackage

FILE: design/distinct_value_table_unit.sv
// Distinct value table: assigns each element of a data set the index of its
// first occurrence, appending values not seen before.
// Input word: in_tdata carries the element, in_tuser[0] marks the first element
// of a new set, which empties the table before the element is handled.
// Result word: out_tdata is the entry index (low 8 bits), out_tuser[0] says
// the value was new and stored, out_tuser[1] says it was new but the table was
// full, so it was dropped and the index reads zero.
// One word is in work at a time; in_tready is low while it is searched.
// Timing: the stored entries are read one per cycle through the single RAM
// read port and each read word is compared with the held value; a hit or a
// miss registers the result in the sequencer, from where it moves to the
// output register. The next word is accepted the cycle after the result moves
// to the output register.
// A stalled out_tready holds the result word; the next input word is still
// taken and searched, but its finished result waits for the output register
// to free up and in_tready stays low meanwhile.
// Reset empties the table (entry count to zero); RAM contents are not cleared
// and never read before written.
// Depends on dvt_pkg, dvt_seq and dvt_ram.
module distinct_value_table_unit
  import dvt_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int ELEM_WIDTH  = ELEM_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [VALUE_W-1:0]    in_tdata,   // [31:0] value
  input  logic [0:0]            in_tuser,   // [0] first
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [MI_W-1:0]       out_tdata,  // [7:0] match_index
  output logic [OUT_USER_W-1:0] out_tuser   // [0] is_new, [1] overflow
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic                  start;
  logic                  seq_ready;
  logic                  res_valid;
  logic                  res_take;
  dvt_result_t           res;
  logic                  rd_en, wr_en;
  logic [IW-1:0]         rd_addr, wr_addr;
  logic [ELEM_WIDTH-1:0] rd_data, wr_data;
  logic                  out_valid_r, out_valid_nxt;
  dvt_result_t           out_res_r, out_res_nxt;

  assign in_tready = seq_ready;
  assign start     = in_tvalid && seq_ready;
  assign res_take  = res_valid && (!out_valid_r || out_tready);

  dvt_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ELEM_WIDTH  (ELEM_WIDTH)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .start_value (ELEM_WIDTH'(in_tdata)),
    .start_first (in_tuser[0]),
    .ready       (seq_ready),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res         (res),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data)
  );

  dvt_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // output register: load a finished result, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.match_index;
  assign out_tuser  = {out_res_r.overflow, out_res_r.is_new};

endmodule

FILE: design/dvt_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
module dvt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/dvt_seq.sv
// Search sequencer: walks the stored entries one per cycle through the RAM read
// port, compares against the held value and appends on a miss unless full.
// Depends on dvt_pkg.
module dvt_seq
  import dvt_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int ELEM_WIDTH  = ELEM_WIDTH_DEF,
  parameter int IW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [ELEM_WIDTH-1:0] start_value,
  input  logic                  start_first,
  output logic                  ready,
  output logic                  res_valid,
  input  logic                  res_take,
  output dvt_result_t           res,
  output logic                  rd_en,
  output logic [IW-1:0]         rd_addr,
  input  logic [ELEM_WIDTH-1:0] rd_data,
  output logic                  wr_en,
  output logic [IW-1:0]         wr_addr,
  output logic [ELEM_WIDTH-1:0] wr_data
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  dvt_state_t            state_r, state_nxt;
  logic [ELEM_WIDTH-1:0] val_r, val_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         addr_r, addr_nxt;
  logic                  pend_r, pend_nxt;
  logic [IW-1:0]         pidx_r, pidx_nxt;
  dvt_result_t           res_r, res_nxt;

  logic hit, scan_more, miss, full;

  assign hit       = pend_r && (rd_data == val_r);
  assign scan_more = (addr_r != cnt_r);
  assign miss      = !hit && !scan_more && !pend_r;
  assign full      = (cnt_r == CW'(TABLE_DEPTH));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (hit || miss) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_take) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ready     = (state_r == ST_IDLE);
    res_valid = (state_r == ST_DONE);
    rd_en     = (state_r == ST_SCAN) && !hit && scan_more;
    rd_addr   = addr_r[IW-1:0];
    wr_en     = (state_r == ST_SCAN) && miss && !full;
    wr_addr   = cnt_r[IW-1:0];
    wr_data   = val_r;
    res       = res_r;
  end

  always_comb begin
    val_nxt  = val_r;
    cnt_nxt  = cnt_r;
    addr_nxt = addr_r;
    pend_nxt = pend_r;
    pidx_nxt = pidx_r;
    res_nxt  = res_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          val_nxt  = start_value;
          addr_nxt = '0;
          pend_nxt = 1'b0;
          if (start_first) cnt_nxt = '0;
        end
      end
      ST_SCAN: begin
        // compare uses the registered read data, with pend_r marking a read in flight
        pend_nxt = rd_en;
        pidx_nxt = addr_r[IW-1:0];
        if (rd_en) addr_nxt = addr_r + 1'b1;
        if (hit) begin
          res_nxt.match_index = MI_W'(pidx_r);
          res_nxt.is_new      = 1'b0;
          res_nxt.overflow    = 1'b0;
        end else if (miss) begin
          if (full) begin
            res_nxt.match_index = '0;
            res_nxt.is_new      = 1'b0;
            res_nxt.overflow    = 1'b1;
          end else begin
            res_nxt.match_index = MI_W'(cnt_r);
            res_nxt.is_new      = 1'b1;
            res_nxt.overflow    = 1'b0;
            cnt_nxt             = cnt_r + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    addr_r <= addr_nxt;
    pidx_r <= pidx_nxt;
    res_r  <= res_nxt;
  end

endmodule

FILE: tb/sv/tb_distinct_value_table_unit.sv
`timescale 1ns / 100ps
// Testbench for distinct_value_table_unit: streams data sets of elements, predicts
// the index, new and overflow flags of each one and checks every result word.
// Depends on dvt_pkg and the distinct_value_table_unit RTL.
module tb_distinct_value_table_unit;
  import dvt_pkg::*;

  localparam int HOLD_CYCLES = 600;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               starts_set;
  } element_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [VALUE_W-1:0]    in_tdata = '0;   // [31:0] value
  logic [0:0]            in_tuser = '0;   // [0] first
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [MI_W-1:0]       out_tdata;       // [7:0] match_index
  logic [OUT_USER_W-1:0] out_tuser;       // [0] is_new, [1] overflow

  element_t       element_fifo[$];
  dvt_result_t    expected_lookups[$];
  logic [VALUE_W-1:0] seen_values[TABLE_DEPTH_DEF];
  int             seen_count = 0;
  int             words_queued = 0;
  int             words_accepted = 0;
  int             mismatches = 0;
  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;
  bit             hold_request = 1'b0;
  bit             holding = 1'b0;

  distinct_value_table_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Search the known values in arrival order; append a miss while there is room.
  function automatic dvt_result_t lookup_value(logic [VALUE_W-1:0] v, logic starts_set);
    dvt_result_t r;
    int hit;
    r = '0;
    hit = -1;
    if (starts_set) seen_count = 0;
    for (int i = 0; i < seen_count; i++)
      if (hit < 0 && seen_values[i] == v) hit = i;
    if (hit >= 0) begin
      r.match_index = hit[MI_W-1:0];
    end else if (seen_count < TABLE_DEPTH_DEF) begin
      seen_values[seen_count] = v;
      r.match_index = seen_count[MI_W-1:0];
      r.is_new = 1'b1;
      seen_count++;
    end else begin
      r.overflow = 1'b1;
    end
    return r;
  endfunction

  task automatic push_element(logic [VALUE_W-1:0] v, logic starts_set);
    element_t e;
    e.value = v;
    e.starts_set = starts_set;
    element_fifo.push_back(e);
    words_queued++;
  endtask

  // Fill the table with distinct values, then mix dropped new values and repeats.
  task automatic add_full_set();
    logic [VALUE_W-1:0] stored[$];
    logic [VALUE_W-1:0] v;
    for (int i = 0; i < TABLE_DEPTH_DEF; i++) begin
      v = ($urandom & 32'hFFFF_FF00) | i;
      stored.push_back(v);
      push_element(v, i == 0);
    end
    push_element(stored[TABLE_DEPTH_DEF-1], 1'b0);
    for (int i = 0; i < 24; i++) begin
      if ($urandom_range(1))
        push_element($urandom, 1'b0);
      else
        push_element(stored[$urandom_range(TABLE_DEPTH_DEF-1)], 1'b0);
    end
    push_element(stored[0], 1'b0);
  endtask

  // Sets, mostly short, drawn from small pools so that repeats are common.
  task automatic add_random_sets(int total);
    logic [VALUE_W-1:0] pool[$];
    int added;
    int n;
    int pool_n;
    added = 0;
    while (added < total) begin
      if ($urandom_range(14) == 0) begin
        n = $urandom_range(40, 90);
        pool_n = 60;
      end else begin
        n = $urandom_range(1, 24);
        pool_n = $urandom_range(1, 12);
      end
      pool.delete();
      for (int i = 0; i < pool_n; i++) begin
        case ($urandom_range(2))
          0: pool.push_back($urandom);
          1: pool.push_back($urandom_range(0, 7));
          default: pool.push_back(~$urandom_range(0, 7));
        endcase
      end
      for (int k = 0; k < n; k++) begin
        if (k == 0)
          push_element(pool[$urandom_range(pool_n-1)], $urandom_range(9) != 0);
        else
          push_element(pool[$urandom_range(pool_n-1)], $urandom_range(49) == 0);
      end
      added += n;
    end
  endtask

  task automatic wait_accepted();
    while (words_accepted < words_queued) @(posedge clk);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    @(posedge clk);
    send_idle_pct <= send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  // Driver: predict on acceptance, then offer the next word or idle.
  always @(posedge clk) begin
    element_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_lookups.push_back(lookup_value(in_tdata, in_tuser[0]));
        words_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (element_fifo.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = element_fifo.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= nxt.value;
          in_tuser <= nxt.starts_set;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result word with the oldest prediction.
  always @(posedge clk) begin
    dvt_result_t exp_r;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_lookups.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: index %0d new %0d overflow %0d",
                     out_tdata, out_tuser[0], out_tuser[1]);
        end else begin
          exp_r = expected_lookups.pop_front();
          if (out_tdata !== exp_r.match_index || out_tuser[0] !== exp_r.is_new ||
              out_tuser[1] !== exp_r.overflow) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected index %0d new %0d overflow %0d, got %0d %0d %0d",
                       words_accepted, exp_r.match_index, exp_r.is_new, exp_r.overflow,
                       out_tdata, out_tuser[0], out_tuser[1]);
          end
        end
      end
      out_tready <= !holding && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Hold off the receiver for a long stretch so the input side backs up.
  initial begin
    wait (hold_request);
    @(posedge clk);
    holding <= 1'b1;
    for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
    holding <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("distinct_value_table_unit: mismatch");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // No first flag since reset: table starts empty.
    push_element(32'h0000_0000, 1'b0);
    push_element(32'hFFFF_FFFF, 1'b0);
    push_element(32'h0000_0000, 1'b0);
    push_element(32'hFFFF_FFFF, 1'b0);
    // First flag clears the table, even on a repeated value.
    push_element(32'hFFFF_FFFF, 1'b1);
    push_element(32'h0000_0000, 1'b0);
    push_element(32'h8000_0000, 1'b0);
    push_element(32'h0000_0001, 1'b0);
    push_element(32'h5555_5555, 1'b0);
    push_element(32'hAAAA_AAAA, 1'b0);
    push_element(32'h8000_0000, 1'b0);
    push_element(32'h0000_0001, 1'b0);
    push_element(32'h0000_0000, 1'b1);
    push_element(32'h0000_0000, 1'b1);
    push_element(32'h0000_0000, 1'b0);
    hold_request = 1'b1;
    add_full_set();
    add_random_sets(60);
    wait_accepted();

    set_idling(68, 0);
    add_random_sets(70);
    wait_accepted();

    set_idling(0, 68);
    add_random_sets(70);
    wait_accepted();

    set_idling(22, 22);
    add_random_sets(70);
    wait_accepted();

    set_idling(0, 0);
    add_random_sets(30);
    wait_accepted();

    while (expected_lookups.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && expected_lookups.size() == 0)
      $display("distinct_value_table_unit: match");
    else
      $display("distinct_value_table_unit: mismatch");
    $finish;
  end

endmodule

FILE: filelist.f
design/dvt_pkg.sv
design/dvt_ram.sv
design/dvt_seq.sv
design/distinct_value_table_unit.sv
tb/sv/tb_distinct_value_table_unit.sv
